@@ rtl/core/mono_framebuffer_rect_drawer_unit_macros.svh @@
// Assertion macros shared by the checker of the framebuffer drawer.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef MONO_FRAMEBUFFER_RECT_DRAWER_UNIT_MACROS_SVH
`define MONO_FRAMEBUFFER_RECT_DRAWER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MFRD_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("framebuffer drawer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MFRD_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("framebuffer drawer assertion failed");

`endif

@@ rtl/core/mfrd_pkg.sv @@
// Shared types and constants of the monochrome framebuffer drawer.
// Used by the coordinate walker, the top level and the checker.
`timescale 1ns / 1ps

package mfrd_pkg;

  localparam int DEF_ROW_BYTES = 32;
  localparam int DEF_ROWS      = 256;
  localparam int COORD_W       = 9;

  localparam logic [1:0] ACT_PIXEL   = 2'd0;
  localparam logic [1:0] ACT_OUTLINE = 2'd1;
  localparam logic [1:0] ACT_FILL    = 2'd2;
  localparam logic [1:0] ACT_READ    = 2'd3;

  localparam logic REG_STROKE = 1'b0;
  localparam logic REG_FILL   = 1'b1;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [8:0] rect_width;
    logic [8:0] rect_height;
  } draw_cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       clipped;
  } draw_rsp_t;

  typedef struct packed {
    logic index;
    logic data;
  } cfg_wr_t;

  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] xr;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] yb;
    logic               outline;
  } walk_cmd_t;

  typedef struct packed {
    logic start;
    logic step;
  } walk_ctrl_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } walk_pos_t;

endpackage

@@ rtl/core/mfrd_chan_if.sv @@
// Valid/ready channel carrying one payload struct per transfer.
// Depends on nothing; the payload type is given at instantiation.
`timescale 1ns / 1ps

interface mfrd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/mfrd_walker.sv @@
// Pixel coordinate walker for rectangles: full rows for fills, edges for outlines.
// Depends on mfrd_pkg.
`timescale 1ns / 1ps

module mfrd_walker import mfrd_pkg::*; (
  input  logic       clk_i,
  input  walk_ctrl_t ctrl_i,
  input  walk_cmd_t  cmd_i,
  output walk_pos_t  pos_o
);

  walk_cmd_t          cmd_q;
  logic [COORD_W-1:0] x_q;
  logic [COORD_W-1:0] y_q;
  logic               full_row;
  logic               row_end;

  always_comb begin
    full_row = !cmd_q.outline || (y_q == cmd_q.y0) || (y_q == cmd_q.yb);
    row_end  = (x_q == cmd_q.xr);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      cmd_q <= cmd_i;
      x_q   <= cmd_i.x0;
      y_q   <= cmd_i.y0;
    end else if (ctrl_i.step) begin
      if (row_end) begin
        x_q <= cmd_q.x0;
        y_q <= y_q + COORD_W'(1);
      end else if (full_row) begin
        x_q <= x_q + COORD_W'(1);
      end else begin
        x_q <= cmd_q.xr;
      end
    end
  end

  assign pos_o.x    = x_q;
  assign pos_o.y    = y_q;
  assign pos_o.last = row_end && (y_q == cmd_q.yb);

endmodule

@@ rtl/core/mono_framebuffer_rect_drawer_unit.sv @@
// Monochrome framebuffer drawer: one pixel read-modify-write at a time on a byte store.
// Rectangles read-modify-write each pixel inside the frame (reads only for ACT_READ) and skip
// clipped pixels; a new command is taken only once the last response has been registered.
// Reset sets both color registers to 1 and then sweeps the store to zero, during which
// no command is taken; configuration writes are taken.
// Depends on mfrd_pkg, mfrd_chan_if and mfrd_walker.
`timescale 1ns / 1ps

module mono_framebuffer_rect_drawer_unit import mfrd_pkg::*; #(
  parameter int ROW_BYTES = DEF_ROW_BYTES,
  parameter int ROWS      = DEF_ROWS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mfrd_chan_if.sink   cfg_i,
  mfrd_chan_if.sink   cmd_i,
  mfrd_chan_if.source rsp_o
);

  localparam int DEPTH  = ROW_BYTES * ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_PIXEL  = 3'd2;
  localparam logic [2:0] ST_MODIFY = 3'd3;
  localparam logic [2:0] ST_RESP   = 3'd4;

  logic [7:0] mem [DEPTH];

  logic [2:0]        state_q, state_d;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic              stroke_q, fill_q;
  logic [1:0]        action_q;
  logic              color_q;
  logic              clip_q;
  logic [7:0]        rd_q;
  logic [ADDR_W-1:0] addr_q;
  logic [2:0]        bit_q;
  logic [7:0]        rdata_q;
  logic              rsp_valid_q;
  draw_rsp_t         rsp_q;

  walk_ctrl_t walk_ctrl;
  walk_cmd_t  walk_cmd;
  walk_pos_t  pos;

  logic              cmd_fire;
  logic              empty_rect;
  logic              in_frame;
  logic [15:0]       addr_full;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mask;
  logic              rsp_load;

  mfrd_walker u_walker (
    .clk_i  (clk_i),
    .ctrl_i (walk_ctrl),
    .cmd_i  (walk_cmd),
    .pos_o  (pos)
  );

  assign cfg_i.ready = 1'b1;
  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  always_comb begin
    empty_rect = ((cmd_i.payload.action == ACT_OUTLINE) || (cmd_i.payload.action == ACT_FILL))
                 && ((cmd_i.payload.rect_width == 9'd0) || (cmd_i.payload.rect_height == 9'd0));
    walk_cmd.x0      = COORD_W'(cmd_i.payload.x_pos);
    walk_cmd.y0      = COORD_W'(cmd_i.payload.y_pos);
    walk_cmd.outline = (cmd_i.payload.action == ACT_OUTLINE);
    if ((cmd_i.payload.action == ACT_OUTLINE) || (cmd_i.payload.action == ACT_FILL)) begin
      walk_cmd.xr = COORD_W'(cmd_i.payload.x_pos) + cmd_i.payload.rect_width - COORD_W'(1);
      walk_cmd.yb = COORD_W'(cmd_i.payload.y_pos) + cmd_i.payload.rect_height - COORD_W'(1);
    end else begin
      walk_cmd.xr = COORD_W'(cmd_i.payload.x_pos);
      walk_cmd.yb = COORD_W'(cmd_i.payload.y_pos);
    end
  end

  always_comb begin
    in_frame  = (pos.y < 9'(ROWS)) && (pos.x[8:3] < 6'(ROW_BYTES));
    addr_full = 16'(pos.y[7:0]) * 16'(ROW_BYTES) + 16'(pos.x[8:3]);
    mask      = 8'b1 << bit_q;
    rsp_load  = (state_q == ST_RESP) && (!rsp_valid_q || rsp_o.ready);
  end

  always_comb begin
    state_d         = state_q;
    walk_ctrl.start = 1'b0;
    walk_ctrl.step  = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_waddr       = addr_q;
    mem_wdata       = color_q ? (rdata_q | mask) : (rdata_q & ~mask);
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = 8'd0;
        if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_fire) begin
          walk_ctrl.start = 1'b1;
          state_d = empty_rect ? ST_RESP : ST_PIXEL;
        end
      end
      ST_PIXEL: begin
        if (in_frame) begin
          mem_re  = 1'b1;
          state_d = ST_MODIFY;
        end else if (pos.last) begin
          state_d = ST_RESP;
        end else begin
          walk_ctrl.step = 1'b1;
        end
      end
      ST_MODIFY: begin
        mem_we = (action_q != ACT_READ);
        if (pos.last) begin
          state_d = ST_RESP;
        end else begin
          walk_ctrl.step = 1'b1;
          state_d = ST_PIXEL;
        end
      end
      ST_RESP: begin
        if (rsp_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[addr_full[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      action_q <= cmd_i.payload.action;
      color_q  <= (cmd_i.payload.action == ACT_FILL) ? fill_q : stroke_q;
      rd_q     <= 8'd0;
    end else if ((state_q == ST_MODIFY) && (action_q == ACT_READ)) begin
      rd_q <= rdata_q;
    end
    if (mem_re) begin
      addr_q <= addr_full[ADDR_W-1:0];
      bit_q  <= pos.x[2:0];
    end
    if (rsp_load) begin
      rsp_q.read_data <= rd_q;
      rsp_q.clipped   <= clip_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      stroke_q    <= 1'b1;
      fill_q      <= 1'b1;
      clip_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.payload.index)
          REG_STROKE: stroke_q <= cfg_i.payload.data;
          REG_FILL:   fill_q   <= cfg_i.payload.data;
          default:    stroke_q <= stroke_q;
        endcase
      end
      if (cmd_fire) begin
        clip_q <= 1'b0;
      end else if ((state_q == ST_PIXEL) && !in_frame) begin
        clip_q <= 1'b1;
      end
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/mfrd_checker.sv @@
// Port-level checker for the framebuffer drawer, bound to the top level.
// Depends on mfrd_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "mono_framebuffer_rect_drawer_unit_macros.svh"

module mfrd_checker import mfrd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      cmd_valid,
  input logic      cmd_ready,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input draw_rsp_t rsp_payload
);

  logic [1:0] pending_q;
  logic       cmd_xfer, rsp_xfer;

  assign cmd_xfer = cmd_valid && cmd_ready;
  assign rsp_xfer = rsp_valid && rsp_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
    end else begin
      pending_q <= pending_q + 2'(cmd_xfer) - 2'(rsp_xfer);
    end
  end

  `MFRD_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid && !rsp_ready,
    rsp_valid && $stable(rsp_payload))
  `MFRD_ASSERT_NEXT(a_busy_after_cmd, clk_i, rst_ni, cmd_xfer, !cmd_ready)
  `MFRD_ASSERT_IMPLIES(a_rsp_has_cmd, clk_i, rst_ni, rsp_valid, pending_q != 2'd0)
  `MFRD_ASSERT_IMPLIES(a_ready_one_waiting, clk_i, rst_ni, cmd_ready, pending_q <= 2'd1)

endmodule

bind mono_framebuffer_rect_drawer_unit mfrd_checker u_mfrd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid   (cmd_i.valid),
  .cmd_ready   (cmd_i.ready),
  .rsp_valid   (rsp_o.valid),
  .rsp_ready   (rsp_o.ready),
  .rsp_payload (rsp_o.payload)
);
